FILE: rtl/core/lbs_pkg.sv
// Shared constants for the linear blend skinning block.
package lbs_pkg;

  localparam int unsigned ElemsPerJoint = 12;
  localparam int unsigned SumW          = 18;
  localparam int unsigned WaccW         = 51;
  localparam int unsigned NumW          = 50;
  localparam int unsigned RowAccW       = 51;
  localparam int unsigned ProdW         = 65;

  localparam logic [SumW-1:0] SumLow    = 18'd32735;
  localparam logic [SumW-1:0] SumHigh   = 18'd32801;
  localparam logic [SumW-1:0] WeightOne = 18'd32768;

  localparam logic [0:0] CfgSkinEnabled = 1'b0;
  localparam logic [0:0] CfgJointCount  = 1'b1;

  localparam logic [0:0] KindPalette = 1'b0;
  localparam logic [0:0] KindVertex  = 1'b1;

endpackage

FILE: rtl/core/linear_blend_skinning.sv
// Four-influence linear blend skinning with a joint matrix palette.
//
// Input channel (in_valid_i/in_ready_o) carries two kinds of transfer.
// A palette transfer (kind 0) writes one Q16.16 element of a joint's 3x4
// matrix and gives no result. A vertex transfer (kind 1) gives one skinned
// position on the output channel (out_valid_o/out_ready_i). A vertex with
// skinning disabled or a zero weight sum passes its position through. A
// skinned vertex runs each of the 12 matrix elements through the shared
// multiplier (for each of 4 influences: palette read, multiply and
// accumulate) and a radix-2 divider, then 3 rows of 3 multiply and
// accumulate steps.
// in_ready_o is high only while the sequencer is idle; one result may wait in
// the output register while the next transfer is taken. If the receiver
// stalls with a result still waiting, the sequencer holds its finished
// result until the output register frees up. Reset clears the configuration
// registers (skinning off, zero joints) and the handshake state; palette
// contents are undefined until written. Configuration writes (cfg_we_i) take
// effect at once; the user must make them while idle, which is not enforced.
module linear_blend_skinning #(
  parameter int unsigned MAX_JOINTS = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_index_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                kind_i,
  input  logic signed [31:0]  pos_x_i,
  input  logic signed [31:0]  pos_y_i,
  input  logic signed [31:0]  pos_z_i,
  input  logic [31:0]         joint_indices_i,
  input  logic [63:0]         influence_weights_i,
  input  logic [6:0]          entry_joint_i,
  input  logic [3:0]          entry_element_i,
  input  logic signed [31:0]  entry_value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  out_x_o,
  output logic signed [31:0]  out_y_o,
  output logic signed [31:0]  out_z_o
);

  import lbs_pkg::*;

  localparam int unsigned Depth = MAX_JOINTS * ElemsPerJoint;
  localparam int unsigned AddrW = $clog2(Depth);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RD     = 4'd1;
  localparam logic [3:0] S_MUL    = 4'd2;
  localparam logic [3:0] S_ACC    = 4'd3;
  localparam logic [3:0] S_DVINIT = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_DVEND  = 4'd6;
  localparam logic [3:0] S_RINIT  = 4'd7;
  localparam logic [3:0] S_RMUL   = 4'd8;
  localparam logic [3:0] S_RACC   = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  localparam logic signed [WaccW-1:0] SatMax = WaccW'(64'sd2147483647);
  localparam logic signed [WaccW-1:0] SatMin = -WaccW'(64'sd2147483648);

  logic [3:0]                 state_q, state_d;
  logic                       skin_en_q;
  logic [7:0]                 joint_count_q;
  logic [3:0]                 e_q;
  logic [1:0]                 i_q;
  logic [1:0]                 r_q;
  logic [1:0]                 c_q;
  logic [5:0]                 dcnt_q;
  logic signed [31:0]         pos_q [3];
  logic [31:0]                idx_q;
  logic [63:0]                wts_q;
  logic [SumW-1:0]            div_q;
  logic signed [WaccW-1:0]    wacc_q;
  logic signed [ProdW-1:0]    prod_q;
  logic [NumW-1:0]            num_q;
  logic [SumW-1:0]            rem_q;
  logic                       neg_q;
  logic signed [31:0]         blend_q [ElemsPerJoint];
  logic signed [RowAccW-1:0]  racc_q;
  logic signed [31:0]         res_q [3];
  logic                       out_valid_q;
  logic signed [31:0]         out_q [3];

  logic                       accept;
  logic [SumW-1:0]            wsum;
  logic                       pal_we;
  logic [AddrW-1:0]           pal_waddr;
  logic [AddrW-1:0]           pal_raddr;
  logic [31:0]                pal_rdata;
  logic [15:0]                cur_w;
  logic [7:0]                 cur_j;
  logic                       cur_used;
  logic [3:0]                 bidx;
  logic signed [32:0]         mul_a;
  logic signed [31:0]         mul_b;
  logic signed [WaccW-1:0]    wacc_new;
  logic [SumW:0]              rem_sh;
  logic                       qbit;
  logic signed [RowAccW-1:0]  racc_new;
  logic signed [RowAccW-1:0]  rterm;
  logic signed [ProdW-1:0]    prod_rnd;
  logic signed [31:0]         blend_new;
  logic signed [31:0]         racc_sat;
  logic                       out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign wsum = SumW'(influence_weights_i[15:0]) + SumW'(influence_weights_i[31:16])
              + SumW'(influence_weights_i[47:32]) + SumW'(influence_weights_i[63:48]);

  assign pal_we = accept && (kind_i == KindPalette)
               && (entry_element_i < 4'(ElemsPerJoint))
               && ({2'b00, entry_joint_i} < 9'(MAX_JOINTS));
  assign pal_waddr = AddrW'(int'(entry_joint_i) * ElemsPerJoint + int'(entry_element_i));

  assign cur_w    = wts_q[16*i_q +: 16];
  assign cur_j    = idx_q[8*i_q +: 8];
  assign cur_used = (cur_w != 16'd0) && (cur_j < joint_count_q)
                 && ({1'b0, cur_j} < 9'(MAX_JOINTS));
  assign pal_raddr = AddrW'(int'(cur_j) * ElemsPerJoint + int'(e_q));

  lbs_ram #(
    .WIDTH(32),
    .DEPTH(Depth)
  ) u_palette (
    .clk_i  (clk_i),
    .we_i   (pal_we),
    .waddr_i(pal_waddr),
    .wdata_i(entry_value_i),
    .raddr_i(pal_raddr),
    .rdata_o(pal_rdata)
  );

  // Shared multiplier: weight x palette element, or blend element x position.
  assign bidx = (state_q == S_RINIT) ? 4'({r_q, 2'b11}) : 4'({r_q, c_q});
  always_comb begin
    if (state_q == S_MUL) begin
      mul_a = $signed({17'd0, cur_w});
      mul_b = $signed(pal_rdata);
    end else begin
      mul_a = 33'(blend_q[bidx]);
      mul_b = pos_q[c_q];
    end
  end

  assign wacc_new = wacc_q + (cur_used ? WaccW'(prod_q) : '0);

  assign rem_sh = {rem_q, num_q[NumW-1]};
  assign qbit   = (rem_sh >= {1'b0, div_q});

  // Round-to-nearest magnitude, then restore sign and saturate.
  always_comb begin
    if (neg_q) begin
      blend_new = (num_q > NumW'(64'd2147483648)) ? 32'sh80000000
                                                    : 32'(-$signed({1'b0, num_q}));
    end else begin
      blend_new = (num_q > NumW'(64'd2147483647)) ? 32'sh7fffffff : 32'(num_q);
    end
  end

  assign prod_rnd = prod_q + ProdW'(32768);
  assign rterm    = RowAccW'(prod_rnd >>> 16);
  assign racc_new = racc_q + rterm;
  assign racc_sat = (racc_new > SatMax) ? 32'sh7fffffff
                  : (racc_new < SatMin) ? 32'sh80000000 : 32'(racc_new);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (kind_i == KindVertex)) begin
          state_d = (!skin_en_q || (wsum == '0)) ? S_DONE : S_RD;
        end
      end
      S_RD:     state_d = S_MUL;
      S_MUL:    state_d = S_ACC;
      S_ACC:    state_d = (i_q == 2'd3) ? S_DVINIT : S_RD;
      S_DVINIT: state_d = S_DIV;
      S_DIV:    state_d = (dcnt_q == 6'(NumW - 1)) ? S_DVEND : S_DIV;
      S_DVEND:  state_d = (e_q == 4'(ElemsPerJoint - 1)) ? S_RINIT : S_RD;
      S_RINIT:  state_d = S_RMUL;
      S_RMUL:   state_d = S_RACC;
      S_RACC: begin
        if (c_q == 2'd2) begin
          state_d = (r_q == 2'd2) ? S_DONE : S_RINIT;
        end else begin
          state_d = S_RMUL;
        end
      end
      S_DONE:   state_d = out_free ? S_IDLE : S_DONE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      skin_en_q     <= 1'b0;
      joint_count_q <= 8'd0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgSkinEnabled: skin_en_q     <= cfg_wdata_i[0];
          CfgJointCount:  joint_count_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          pos_q[0] <= pos_x_i;
          pos_q[1] <= pos_y_i;
          pos_q[2] <= pos_z_i;
          res_q[0] <= pos_x_i;
          res_q[1] <= pos_y_i;
          res_q[2] <= pos_z_i;
          idx_q    <= joint_indices_i;
          wts_q    <= influence_weights_i;
          div_q    <= ((wsum < SumLow) || (wsum > SumHigh)) ? wsum : WeightOne;
          wacc_q   <= '0;
          e_q      <= 4'd0;
          i_q      <= 2'd0;
          r_q      <= 2'd0;
          c_q      <= 2'd0;
        end
      end
      S_MUL: prod_q <= mul_a * mul_b;
      S_ACC: begin
        wacc_q <= wacc_new;
        i_q    <= i_q + 2'd1;
      end
      S_DVINIT: begin
        neg_q  <= wacc_q[WaccW-1];
        num_q  <= NumW'(wacc_q[WaccW-1] ? -wacc_q : wacc_q) + NumW'(div_q >> 1);
        rem_q  <= '0;
        dcnt_q <= 6'd0;
      end
      S_DIV: begin
        rem_q  <= qbit ? SumW'(rem_sh - {1'b0, div_q}) : rem_sh[SumW-1:0];
        num_q  <= {num_q[NumW-2:0], qbit};
        dcnt_q <= dcnt_q + 6'd1;
      end
      S_DVEND: begin
        blend_q[e_q] <= blend_new;
        wacc_q       <= '0;
        e_q          <= e_q + 4'd1;
      end
      S_RINIT: begin
        racc_q <= RowAccW'(blend_q[bidx]);
        c_q    <= 2'd0;
      end
      S_RMUL: prod_q <= mul_a * mul_b;
      S_RACC: begin
        if (c_q == 2'd2) begin
          res_q[r_q] <= racc_sat;
          r_q        <= r_q + 2'd1;
        end else begin
          racc_q <= racc_new;
          c_q    <= c_q + 2'd1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_q[0] <= res_q[0];
          out_q[1] <= res_q[1];
          out_q[2] <= res_q[2];
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_q[0];
  assign out_y_o     = out_q[1];
  assign out_z_o     = out_q[2];

endmodule

FILE: rtl/core/lbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
